/* rtl/distance_attenuation_doppler_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for distance_attenuation_doppler
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_ATTENUATION_DOPPLER_ASSERT_SVH
`define DISTANCE_ATTENUATION_DOPPLER_ASSERT_SVH

// same-cycle implication
`define DAD_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("distance_attenuation_doppler: check failed");

// next-cycle implication
`define DAD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("distance_attenuation_doppler: check failed");

`endif

/* rtl/dad_pkg.sv */
// ----------------------------------------------------------------------------
// dad_pkg
// Shared constants, codes and stage payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package dad_pkg;

	localparam int SQRT_STEPS_DFLT = 2;   // root bits per sqrt stage
	localparam int DIV_STEPS_DFLT  = 2;   // quotient bits per divider stage

	localparam int DIST_EPS  = 66;        // 0.001 in Q16.16, rounded up
	localparam int SPEED_Q16 = 22478848;  // 343.0 m/s in Q16.16
	localparam int ONE_Q16   = 65536;
	localparam int DOP_MIN   = 2048;
	localparam int DOP_MAX   = 8192;
	localparam int DOP_UNIT  = 4096;

	typedef enum logic [1:0] {
		PLACE_NONE  = 2'd0,
		PLACE_REL   = 2'd1,
		PLACE_WORLD = 2'd2
	} place_t;

	typedef enum logic [2:0] {
		REG_LX  = 3'd0,
		REG_LY  = 3'd1,
		REG_LZ  = 3'd2,
		REG_LVX = 3'd3,
		REG_LVY = 3'd4,
		REG_LVZ = 3'd5
	} reg_idx_t;

	// source context up to the distance
	typedef struct packed {
		logic [2:0]       neg;
		logic [2:0][32:0] mag;
		logic [2:0][31:0] svel;
		logic [31:0]      ref_d;
		logic [31:0]      max_d;
		logic [23:0]      roll;
		logic [15:0]      gain;
		logic [15:0]      pitch;
		logic [1:0]       placement;
	} src_t;

	typedef struct packed {
		logic scale;
		src_t src;
	} sq_pay_t;

	// context through the volume / unit-vector dividers
	typedef struct packed {
		logic             den_le0;
		logic             vsat;
		logic             dop_en;
		logic [2:0]       neg;
		logic [2:0][31:0] svel;
		logic [15:0]      gain;
		logic [15:0]      pitch;
		logic [1:0]       placement;
	} vdiv_pay_t;

	typedef struct packed {
		logic        dop_en;
		logic [15:0] vol;
		logic [15:0] gain;
		logic [15:0] pitch;
		logic [1:0]  placement;
	} tail_t;

	typedef struct packed {
		tail_t c;
		logic  dlow;
		logic  dhigh;
	} ddiv_pay_t;

endpackage

`default_nettype wire

/* rtl/dad_sqrt.sv */
// ----------------------------------------------------------------------------
// dad_sqrt
// Pipelined integer square root, floor(sqrt(rad)), STEPS root bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dad_sqrt #(
	parameter int IN_W  = 64,
	parameter int STEPS = 2,
	parameter int PW    = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [IN_W-1:0]   rad,
	input  wire logic [PW-1:0]     in_pay,
	output logic                   out_valid,
	output logic [IN_W/2-1:0]      root,
	output logic [PW-1:0]          out_pay
);

	localparam int R  = IN_W / 2;
	localparam int NS = (R + STEPS - 1) / STEPS;
	localparam int RW = R + 2;

	logic            vld   [NS+1];
	logic [IN_W-1:0] rad_p [NS+1];
	logic [RW-1:0]   rem_p [NS+1];
	logic [R-1:0]    root_p[NS+1];
	logic [PW-1:0]   pay_p [NS+1];

	assign vld[0]    = in_valid;
	assign rad_p[0]  = rad;
	assign rem_p[0]  = '0;
	assign root_p[0] = '0;
	assign pay_p[0]  = in_pay;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [IN_W-1:0] v_n;
		logic [RW-1:0]   rm_n;
		logic [R-1:0]    rt_n;

		always_comb begin
			logic [RW-1:0] trial;
			v_n  = rad_p[k];
			rm_n = rem_p[k];
			rt_n = root_p[k];
			for (int j = 0; j < STEPS; j++) begin
				if (k * STEPS + j < R) begin
					// bring down the next two radicand bits
					rm_n  = {rm_n[RW-3:0], v_n[IN_W-1:IN_W-2]};
					v_n   = {v_n[IN_W-3:0], 2'b00};
					trial = {rt_n, 2'b01};
					if (rm_n >= trial) begin
						rm_n = rm_n - trial;
						rt_n = {rt_n[R-2:0], 1'b1};
					end else begin
						rt_n = {rt_n[R-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_p[k+1]  <= v_n;
				rem_p[k+1]  <= rm_n;
				root_p[k+1] <= rt_n;
				pay_p[k+1]  <= pay_p[k];
			end
		end
	end

	assign out_valid = vld[NS];
	assign root      = root_p[NS];
	assign out_pay   = pay_p[NS];

endmodule

`default_nettype wire

/* rtl/dad_div.sv */
// ----------------------------------------------------------------------------
// dad_div
// Pipelined restoring divider, STEPS quotient bits per stage.
// Needs num < den * 2^Q_W and DEN_W + Q_W >= NUM_W.
// ----------------------------------------------------------------------------
`default_nettype none

module dad_div #(
	parameter int NUM_W = 62,
	parameter int DEN_W = 33,
	parameter int Q_W   = 31,
	parameter int STEPS = 2,
	parameter int PW    = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [PW-1:0]    in_pay,
	output logic                  out_valid,
	output logic [Q_W-1:0]        quo,
	output logic [PW-1:0]         out_pay
);

	localparam int NS = (Q_W + STEPS - 1) / STEPS;
	localparam int W  = DEN_W + Q_W;

	logic             vld  [NS+1];
	logic [NUM_W-1:0] rem_p[NS+1];
	logic [DEN_W-1:0] den_p[NS+1];
	logic [Q_W-1:0]   q_p  [NS+1];
	logic [PW-1:0]    pay_p[NS+1];

	assign vld[0]   = in_valid;
	assign rem_p[0] = num;
	assign den_p[0] = den;
	assign q_p[0]   = '0;
	assign pay_p[0] = in_pay;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [W-1:0]   r_n;
		logic [Q_W-1:0] q_n;

		always_comb begin
			logic [W-1:0] dsh;
			r_n = W'(rem_p[k]);
			q_n = q_p[k];
			for (int j = 0; j < STEPS; j++) begin
				if (k * STEPS + j < Q_W) begin
					dsh = W'(den_p[k]) << (Q_W - 1 - (k * STEPS + j));
					if (r_n >= dsh) begin
						r_n = r_n - dsh;
						q_n = {q_n[Q_W-2:0], 1'b1};
					end else begin
						q_n = {q_n[Q_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_p[k+1] <= r_n[NUM_W-1:0];
				den_p[k+1] <= den_p[k];
				q_p[k+1]   <= q_n;
				pay_p[k+1] <= pay_p[k];
			end
		end
	end

	assign out_valid = vld[NS];
	assign quo       = q_p[NS];
	assign out_pay   = pay_p[NS];

endmodule

`default_nettype wire

/* rtl/distance_attenuation_doppler.sv */
// ----------------------------------------------------------------------------
// distance_attenuation_doppler
// Per-source distance attenuation and Doppler pitch, fully pipelined.
// ----------------------------------------------------------------------------
// One source enters per clock and one result leaves per clock while the pipe
// advances. The square root sits between registers s3 and s4, the volume and
// unit-vector dividers between s7 and s8 and the Doppler divider between s11
// and s12. The whole pipe advances together: it moves whenever the output
// register is empty or its result is being taken, so s_tready falls only
// while a finished result sits unclaimed. Listener position and velocity are
// written through wr_en/wr_index/wr_data and must only change while the pipe
// is empty. Sources with placement other than world-positioned pass gain and
// pitch straight through; the computed values are discarded at the end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_attenuation_doppler_assert.svh"

module distance_attenuation_doppler
	import dad_pkg::*;
#(
	parameter int SQRT_STEPS = SQRT_STEPS_DFLT,
	parameter int DIV_STEPS  = DIV_STEPS_DFLT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// config write port
	input  wire logic         wr_en,
	input  wire logic [2:0]   wr_index,
	input  wire logic [31:0]  wr_data,
	// source stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// source_x, source_y, source_z, source_vel_x, source_vel_y, source_vel_z,
	// ref_distance, max_distance, rolloff_factor[24], gain[16], pitch[16]
	input  wire logic [311:0] s_tdata,
	input  wire logic [1:0]   s_tuser,  // placement
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [31:0]       m_tdata,  // volume, playback_pitch
	output logic [1:0]        m_tuser   // blend_valid, spatial_blend
);

	// ---------------- listener registers ----------------
	logic signed [31:0] lpos_q[3];
	logic signed [31:0] lvel_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				lpos_q[a] <= '0;
				lvel_q[a] <= '0;
			end
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LX:  lpos_q[0] <= wr_data;
				REG_LY:  lpos_q[1] <= wr_data;
				REG_LZ:  lpos_q[2] <= wr_data;
				REG_LVX: lvel_q[0] <= wr_data;
				REG_LVY: lvel_q[1] <= wr_data;
				REG_LVZ: lvel_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	// global advance: output register empty or being taken
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_s9, v_s10, v_s11, v_s12, v_s13;
	logic v_sq, v_vd, v_dd;

	assign adv      = !v_s13 || m_tready;
	assign s_tready = adv;

	// ---------------- s1: offset from listener ----------------
	src_t src_c, src_s1;

	always_comb begin
		logic signed [32:0] d;
		src_c = '0;
		for (int a = 0; a < 3; a++) begin
			d = $signed({s_tdata[32*a+31], s_tdata[32*a +: 32]})
			    - $signed({lpos_q[a][31], lpos_q[a]});
			src_c.neg[a]  = d[32];
			src_c.mag[a]  = d[32] ? 33'(-d) : 33'(d);
			src_c.svel[a] = s_tdata[96+32*a +: 32];
		end
		src_c.ref_d     = s_tdata[223:192];
		src_c.max_d     = s_tdata[255:224];
		src_c.roll      = s_tdata[279:256];
		src_c.gain      = s_tdata[295:280];
		src_c.pitch     = s_tdata[311:296];
		src_c.placement = s_tuser;
	end

	// ---------------- s2: squares ----------------
	logic        scale_c;
	logic [61:0] sq_c[3];
	logic [61:0] sq_s2[3];
	logic        scale_s2;
	src_t        src_s2;

	always_comb begin
		logic [30:0] h;
		// any axis at 2^31 or above: halve all, double the root later
		scale_c = |{src_s1.mag[0][32:31], src_s1.mag[1][32:31], src_s1.mag[2][32:31]};
		for (int a = 0; a < 3; a++) begin
			h       = scale_c ? src_s1.mag[a][31:1] : src_s1.mag[a][30:0];
			sq_c[a] = h * h;
		end
	end

	// ---------------- s3: sum of squares ----------------
	logic [63:0] rad_s3;
	sq_pay_t     sqp_s3, sqp_r;
	logic [31:0] root_r;

	dad_sqrt #(
		.IN_W  (64),
		.STEPS (SQRT_STEPS),
		.PW    ($bits(sq_pay_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.rad       (rad_s3),
		.in_pay    (sqp_s3),
		.out_valid (v_sq),
		.root      (root_r),
		.out_pay   (sqp_r)
	);

	// ---------------- s4: distance, clamp ----------------
	logic [32:0]        dist_c, dist_s4;
	logic [31:0]        refm_c, refm_s4;
	logic signed [34:0] cmr_c, cmr_s4;
	logic               dop_en_s4;
	src_t               src_s4;

	always_comb begin
		logic [32:0] c;
		dist_c = sqp_r.scale ? {root_r, 1'b0} : {1'b0, root_r};
		refm_c = (sqp_r.src.ref_d < 32'(DIST_EPS)) ? 32'(DIST_EPS) : sqp_r.src.ref_d;
		c      = (dist_c > {1'b0, refm_c}) ? dist_c : {1'b0, refm_c};
		// all-ones maximum means unlimited
		if (sqp_r.src.max_d != '1 && c > {1'b0, sqp_r.src.max_d}) begin
			c = {1'b0, sqp_r.src.max_d};
		end
		cmr_c = $signed({2'b00, c}) - $signed({3'b000, refm_c});
	end

	// ---------------- s5: rolloff product, gain*ref ----------------
	logic signed [59:0] prod_s5;
	logic [47:0]        numv_s5, numv_s6;
	logic [31:0]        refm_s5;
	logic [32:0]        dist_s5, dist_s6;
	logic               dop_en_s5, dop_en_s6;
	src_t               src_s5, src_s6;

	// ---------------- s6: denominator ----------------
	logic signed [44:0] den_s6;

	// ---------------- s7: volume range check, divider operands ----------------
	logic        den_le0_c, vsat_c;
	logic [47:0] vnum_s7;
	logic [43:0] vden_s7;
	logic [61:0] unum_s7[3];
	logic [32:0] dist_s7;
	vdiv_pay_t   vp_c, vp_s7, vp_r;

	always_comb begin
		den_le0_c = den_s6[44] || (den_s6 == '0);
		vsat_c    = !den_le0_c && ({12'b0, numv_s6} >= {den_s6[43:0], 16'b0});
		vp_c.den_le0   = den_le0_c;
		vp_c.vsat      = vsat_c;
		vp_c.dop_en    = dop_en_s6;
		vp_c.neg       = src_s6.neg;
		vp_c.svel      = src_s6.svel;
		vp_c.gain      = src_s6.gain;
		vp_c.pitch     = src_s6.pitch;
		vp_c.placement = src_s6.placement;
	end

	logic [30:0] vq_r;
	logic [30:0] uq_r[3];

	dad_div #(
		.NUM_W (48),
		.DEN_W (44),
		.Q_W   (31),
		.STEPS (DIV_STEPS),
		.PW    ($bits(vdiv_pay_t))
	) u_vol_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s7),
		.num       (vnum_s7),
		.den       (vden_s7),
		.in_pay    (vp_s7),
		.out_valid (v_vd),
		.quo       (vq_r),
		.out_pay   (vp_r)
	);

	// unit vector: |d| * 2^29 / dist per axis, same latency as the volume divide
	for (genvar a = 0; a < 3; a++) begin : g_unit
		dad_div #(
			.NUM_W (62),
			.DEN_W (33),
			.Q_W   (31),
			.STEPS (DIV_STEPS),
			.PW    (1)
		) u_unit_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (v_s7),
			.num       (unum_s7[a]),
			.den       (dist_s7),
			.in_pay    (1'b0),
			.out_valid (),
			.quo       (uq_r[a]),
			.out_pay   ()
		);
	end

	// ---------------- s8: signed unit vector, volume ----------------
	logic signed [31:0] u_c[3], u_s8[3];
	logic [15:0]        vol_c;
	tail_t              tl_c, tl_s8, tl_s9, tl_s10;
	logic [2:0][31:0]   svel_s8;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			u_c[a] = vp_r.neg[a] ? -$signed({1'b0, uq_r[a]}) : $signed({1'b0, uq_r[a]});
		end
		if (vp_r.vsat) begin
			vol_c = 16'hFFFF;
		end else if (vp_r.den_le0) begin
			vol_c = (vp_r.gain != '0) ? 16'hFFFF : 16'h0000;
		end else begin
			vol_c = vq_r[15:0];
		end
		tl_c.dop_en    = vp_r.dop_en;
		tl_c.vol       = vol_c;
		tl_c.gain      = vp_r.gain;
		tl_c.pitch     = vp_r.pitch;
		tl_c.placement = vp_r.placement;
	end

	// ---------------- s9: velocity projections ----------------
	logic signed [63:0] pl_s9[3], ps_s9[3];

	// ---------------- s10: closing speeds ----------------
	logic signed [37:0] num_c, dd_c, num_s10, dd_s10;

	always_comb begin
		logic signed [65:0] pl, ps;
		pl = 66'(pl_s9[0]) + 66'(pl_s9[1]) + 66'(pl_s9[2]);
		ps = 66'(ps_s9[0]) + 66'(ps_s9[1]) + 66'(ps_s9[2]);
		num_c = 38'(SPEED_Q16) + $signed({pl[65], pl[65:29]});
		dd_c  = 38'(SPEED_Q16) + $signed({ps[65], ps[65:29]});
		if (dd_c < 38'(ONE_Q16)) begin
			dd_c = 38'(ONE_Q16);
		end
	end

	// ---------------- s11: Doppler range check, divider operands ----------------
	logic        dlow_c, dhigh_c;
	logic [48:0] dnum_s11;
	logic [36:0] dden_s11;
	ddiv_pay_t   dp_c, dp_s11, dp_r;
	logic [12:0] dq_r;

	always_comb begin
		dlow_c  = num_s10[37] || (num_s10 == '0);
		// factor reaches 2.0 once num >= 2*dd
		dhigh_c = !dlow_c && ({1'b0, num_s10[36:0]} >= {dd_s10[36:0], 1'b0});
		dp_c.c     = tl_s10;
		dp_c.dlow  = dlow_c;
		dp_c.dhigh = dhigh_c;
	end

	dad_div #(
		.NUM_W (49),
		.DEN_W (37),
		.Q_W   (13),
		.STEPS (DIV_STEPS),
		.PW    ($bits(ddiv_pay_t))
	) u_dop_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s11),
		.num       (dnum_s11),
		.den       (dden_s11),
		.in_pay    (dp_s11),
		.out_valid (v_dd),
		.quo       (dq_r),
		.out_pay   (dp_r)
	);

	// ---------------- s12: Doppler factor ----------------
	logic [13:0] dop_c, dop_s12;
	tail_t       ctx_c;
	ddiv_pay_t   ctx_s12;

	always_comb begin
		ctx_c = dp_r.c;
		if (!dp_r.c.dop_en) begin
			dop_c = 14'(DOP_UNIT);
		end else if (dp_r.dlow) begin
			dop_c = 14'(DOP_MIN);
		end else if (dp_r.dhigh) begin
			dop_c = 14'(DOP_MAX);
		end else if ({1'b0, dq_r} < 14'(DOP_MIN)) begin
			dop_c = 14'(DOP_MIN);
		end else begin
			dop_c = {1'b0, dq_r};
		end
	end

	// ---------------- s13: pitch scaling, output register ----------------
	logic [15:0] vol_o, pp_o, vol_s13, pp_s13;
	logic        bv_o, bl_o, bv_s13, bl_s13;

	always_comb begin
		logic [29:0] pfull;
		pfull = ctx_s12.c.pitch * dop_s12;
		pp_o  = (pfull[29:28] != 2'b00) ? 16'hFFFF : pfull[27:12];
		vol_o = ctx_s12.c.vol;
		bv_o  = (ctx_s12.c.placement == PLACE_REL) || (ctx_s12.c.placement == PLACE_WORLD);
		bl_o  = (ctx_s12.c.placement == PLACE_WORLD);
		// everything but world-positioned passes gain and pitch through
		if (ctx_s12.c.placement != PLACE_WORLD) begin
			vol_o = ctx_s12.c.gain;
			pp_o  = ctx_s12.c.pitch;
		end
	end

	// ---------------- valid chain ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (adv) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_sq;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_vd;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_dd;
			v_s13 <= v_s12;
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1 <= src_c;

			for (int a = 0; a < 3; a++) begin
				sq_s2[a] <= sq_c[a];
			end
			scale_s2 <= scale_c;
			src_s2   <= src_s1;

			rad_s3     <= 64'(sq_s2[0]) + 64'(sq_s2[1]) + 64'(sq_s2[2]);
			sqp_s3.scale <= scale_s2;
			sqp_s3.src   <= src_s2;

			dist_s4   <= dist_c;
			refm_s4   <= refm_c;
			cmr_s4    <= cmr_c;
			dop_en_s4 <= (dist_c >= 33'(DIST_EPS));
			src_s4    <= sqp_r.src;

			prod_s5   <= cmr_s4 * $signed({1'b0, src_s4.roll});
			numv_s5   <= src_s4.gain * refm_s4;
			refm_s5   <= refm_s4;
			dist_s5   <= dist_s4;
			dop_en_s5 <= dop_en_s4;
			src_s5    <= src_s4;

			den_s6    <= $signed({13'b0, refm_s5}) + $signed({prod_s5[59], prod_s5[59:16]});
			numv_s6   <= numv_s5;
			dist_s6   <= dist_s5;
			dop_en_s6 <= dop_en_s5;
			src_s6    <= src_s5;

			vnum_s7 <= (den_le0_c || vsat_c) ? 48'd0 : numv_s6;
			vden_s7 <= den_le0_c ? 44'd1 : den_s6[43:0];
			for (int a = 0; a < 3; a++) begin
				unum_s7[a] <= {src_s6.mag[a], 29'b0};
			end
			dist_s7 <= dist_s6;
			vp_s7   <= vp_c;

			for (int a = 0; a < 3; a++) begin
				u_s8[a] <= u_c[a];
			end
			svel_s8 <= vp_r.svel;
			tl_s8   <= tl_c;

			for (int a = 0; a < 3; a++) begin
				pl_s9[a] <= lvel_q[a] * u_s8[a];
				ps_s9[a] <= $signed(svel_s8[a]) * u_s8[a];
			end
			tl_s9 <= tl_s8;

			num_s10 <= num_c;
			dd_s10  <= dd_c;
			tl_s10  <= tl_s9;

			dnum_s11 <= (dlow_c || dhigh_c) ? 49'd0 : {num_s10[36:0], 12'b0};
			dden_s11 <= dd_s10[36:0];
			dp_s11   <= dp_c;

			dop_s12       <= dop_c;
			ctx_s12.c     <= ctx_c;
			ctx_s12.dlow  <= dp_r.dlow;
			ctx_s12.dhigh <= dp_r.dhigh;

			vol_s13 <= vol_o;
			pp_s13  <= pp_o;
			bv_s13  <= bv_o;
			bl_s13  <= bl_o;
		end
	end

	assign m_tvalid = v_s13;
	assign m_tdata  = {pp_s13, vol_s13};
	assign m_tuser  = {bl_s13, bv_s13};

	// ---------------- assertions ----------------
	`DAD_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v_s1)
	`DAD_ASSERT_NOW(a_dop_range, v_s12, (dop_s12 >= 14'(DOP_MIN)) && (dop_s12 <= 14'(DOP_MAX)))
	`DAD_ASSERT_NEXT(a_pass_gain, adv && v_s12 && (ctx_s12.c.placement != PLACE_WORLD), m_tdata[15:0] == $past(ctx_s12.c.gain))

endmodule

`default_nettype wire
